/* hw/rtl/aasa_pkg.sv */
// ----------------------------------------------------------------------------
// aasa_pkg
// Types and constants shared by the assembly area size adjuster.
// ----------------------------------------------------------------------------
package aasa_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_READ_THRESHOLD  = 3'd0,
    CFG_AREA_FLOOR      = 3'd1,
    CFG_AREA_GROW_STEP  = 3'd2,
    CFG_EVICT_ADD_LIMIT = 3'd3,
    CFG_PROTECT_MIN     = 3'd4
  } cfg_idx_t;

  localparam logic [7:0]  READ_THRESHOLD_RST  = 8'd2;
  localparam logic [7:0]  AREA_FLOOR_RST      = 8'd2;
  localparam logic [3:0]  AREA_GROW_STEP_RST  = 4'd2;
  localparam logic [15:0] EVICT_ADD_LIMIT_RST = 16'd512;
  localparam logic [15:0] PROTECT_MIN_RST     = 16'd512;

  // Reciprocal constants: x/7 for x < 2^18, x/70 for x < 2^21
  localparam logic [18:0] DIV7_MUL    = 19'd299594;
  localparam int          DIV7_SHIFT  = 21;
  localparam logic [21:0] DIV70_MUL   = 22'd3834793;
  localparam int          DIV70_SHIFT = 28;

  typedef struct packed {
    logic [7:0]  read_threshold;
    logic [7:0]  area_floor;
    logic [3:0]  area_grow_step;
    logic [15:0] evict_add_limit;
    logic [15:0] protect_min;
  } cfg_t;

  typedef struct packed {
    logic [15:0] reads_this_round;
    logic [9:0]  area_size;
    logic [15:0] cache_size;
    logic [20:0] window_size;
    logic [15:0] evict_adds;
    logic [15:0] protected_count;
  } item_t;

  typedef struct packed {
    logic [3:0]  area_change;
    logic [21:0] window_change;
  } result_t;

endpackage

/* hw/rtl/aasa_decide.sv */
// ----------------------------------------------------------------------------
// aasa_decide
// Per-round decision logic: run counter update and area/window changes.
// ----------------------------------------------------------------------------
module aasa_decide (
  input  aasa_pkg::item_t   item,
  input  aasa_pkg::cfg_t    cfg,
  input  logic [15:0]       low_run,
  input  logic [3:0]        held_ac,
  output aasa_pkg::result_t res,
  output logic [15:0]       low_run_next
);
  import aasa_pkg::*;

  logic [16:0]        mem;
  logic [19:0]        mem5;
  logic [16:0]        ceil1;
  logic [20:0]        win_low1;
  logic [20:0]        win_high;
  logic [36:0]        prod7;
  logic [42:0]        prod70;
  logic [15:0]        hq;
  logic [14:0]        wq;
  logic signed [22:0] t_step;
  logic signed [22:0] t_sum;
  logic signed [22:0] prop;
  logic               hi_round;
  logic [15:0]        run_sat;
  logic [15:0]        run_inc;
  logic [15:0]        area6;
  logic               grow_br;
  logic [8:0]         floor1;
  logic               above_floor;
  logic               near_low;
  logic               grow_fits;
  logic [10:0]        area_plus;
  logic [3:0]         ac;
  logic signed [22:0] wc;

  always_comb begin
    mem      = 17'(item.area_size) + 17'(item.cache_size);
    mem5     = (20'(mem) << 2) + 20'(mem);
    ceil1    = mem5[19:3] + 17'd1;               // area_ceil + 1
    win_low1 = 21'({mem, 1'b0}) + 21'd1;         // win_low + 1
    win_high = (21'(mem) << 4) + (21'(mem) << 2);

    // win_high/70 == (2*mem)/7
    prod7  = 37'({mem, 1'b0}) * 37'(DIV7_MUL);
    hq     = prod7[DIV7_SHIFT +: 16];
    prod70 = 43'(item.window_size) * 43'(DIV70_MUL);
    wq     = prod70[DIV70_SHIFT +: 15];
    t_step = $signed(23'(hq)) - $signed(23'(wq));
    t_sum  = $signed(23'(item.window_size)) + t_step;
    if (t_sum <= $signed(23'(win_high))) begin
      prop = t_step;
    end else begin
      prop = $signed(23'(win_high)) - $signed(23'(item.window_size));
    end

    hi_round = item.reads_this_round > 16'(cfg.read_threshold);
    run_sat  = (low_run == 16'hFFFF) ? low_run : low_run + 16'd1;
    run_inc  = hi_round ? 16'd0 : run_sat;
    area6    = (16'(item.area_size) << 2) + (16'(item.area_size) << 1);
    grow_br  = run_inc > area6;

    floor1      = 9'(cfg.area_floor) + 9'd1;
    above_floor = 11'(item.area_size) >= 11'(floor1);
    near_low    = item.window_size <= win_low1;
    grow_fits   = 17'(11'(item.area_size) + 11'(cfg.area_grow_step)) <= ceil1;

    ac = held_ac;
    if (grow_br) begin
      if (grow_fits) begin
        ac = cfg.area_grow_step;
      end
      wc = near_low ? 23'sd1 : 23'sd0;
    end else if (hi_round) begin
      if (above_floor) begin
        ac = 4'd0;
      end
      wc = prop;
    end else if (run_inc[1:0] == 2'd0) begin
      ac = 4'd1;
      wc = near_low ? 23'sd1 : 23'sd0;
    end else begin
      ac = 4'd1;
      wc = 23'sd1;
    end

    area_plus = 11'(item.area_size) + 11'(ac);
    if (area_plus < 11'(floor1) || 17'(area_plus) > ceil1) begin
      ac = 4'd1;
      wc = 23'sd1;
    end

    if (item.evict_adds > cfg.evict_add_limit) begin
      if (above_floor) begin
        ac = 4'd0;
        wc = prop;
      end else begin
        ac = 4'd1;
        wc = 23'sd0;
      end
    end

    if (item.protected_count < cfg.protect_min) begin
      wc = 23'sd0;
    end

    res.area_change   = ac;
    res.window_change = wc[21:0];
    low_run_next      = grow_br ? 16'd0 : run_inc;
  end

endmodule

/* hw/rtl/assembly_area_size_adjuster.sv */
// ----------------------------------------------------------------------------
// assembly_area_size_adjuster
// Picks the assembly area change code and look-ahead window change for each
// restore round.
//
//   channel  dir  handshake             payload
//   s_*      in   s_tvalid / s_tready   s_tdata[95:0]  round statistics
//   m_*      out  m_tvalid / m_tready   m_tdata[31:0]  area / window change
//   cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while results are taken. An accepted input
// goes into the input register, then through the decision logic into the
// result register, which drives the result stream.
// The round-to-round run counter closes its loop in that single decision stage.
// Reset (rst, synchronous) empties both stages and loads register defaults.
// A stalled result holds the pipe; input is still taken while the input
// stage is free or moving on.
// ----------------------------------------------------------------------------
module assembly_area_size_adjuster (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // reads_this_round[15:0], area_size[25:16], cache_size[41:26],
  // window_size[62:42], evict_adds[78:63], protected_count[94:79], zero[95]
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // area_change[3:0], window_change[25:4], zero[31:26]
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import aasa_pkg::*;

  cfg_t        cfg;
  logic        s1_valid;
  item_t       s1_item;
  logic        advance;
  result_t     res;
  logic [15:0] low_run;
  logic [15:0] low_run_next;
  logic [3:0]  held_ac;
  logic        out_valid;
  result_t     out_res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'd0, out_res.window_change, out_res.area_change};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_threshold  <= READ_THRESHOLD_RST;
      cfg.area_floor      <= AREA_FLOOR_RST;
      cfg.area_grow_step  <= AREA_GROW_STEP_RST;
      cfg.evict_add_limit <= EVICT_ADD_LIMIT_RST;
      cfg.protect_min     <= PROTECT_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_READ_THRESHOLD:  cfg.read_threshold  <= cfg_data[7:0];
        CFG_AREA_FLOOR:      cfg.area_floor      <= cfg_data[7:0];
        CFG_AREA_GROW_STEP:  cfg.area_grow_step  <= cfg_data[3:0];
        CFG_EVICT_ADD_LIMIT: cfg.evict_add_limit <= cfg_data;
        CFG_PROTECT_MIN:     cfg.protect_min     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.reads_this_round <= s_tdata[15:0];
      s1_item.area_size        <= s_tdata[25:16];
      s1_item.cache_size       <= s_tdata[41:26];
      s1_item.window_size      <= s_tdata[62:42];
      s1_item.evict_adds       <= s_tdata[78:63];
      s1_item.protected_count  <= s_tdata[94:79];
    end
  end

  aasa_decide u_decide (
    .item         (s1_item),
    .cfg          (cfg),
    .low_run      (low_run),
    .held_ac      (held_ac),
    .res          (res),
    .low_run_next (low_run_next)
  );

  // result stage and round state; the held window change is always
  // overwritten by every branch, so only the area code is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      low_run   <= 16'd0;
      held_ac   <= 4'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        low_run   <= low_run_next;
        held_ac   <= res.area_change;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  a_held_matches_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] == held_ac)
    else $error("held area code differs from the shown result");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while both stages are stalled");

  a_advance_shows_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("decided round did not reach the output");

  a_reset_clears_run: assert property (@(posedge clk)
    $past(rst) |-> low_run == 16'd0 && !m_tvalid && !s1_valid)
    else $error("state not cleared by reset");

endmodule

/* tb/assembly_area_size_adjuster_tb.sv */
// ----------------------------------------------------------------------------
// assembly_area_size_adjuster_tb
// Self-checking bench for the assembly area size adjuster. Rounds go in on
// the stream slave side and a local model predicts the area and window change
// of each one. Every result transaction is compared with the oldest
// prediction. Register settings change only while the pipe is empty. Sender
// gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
module assembly_area_size_adjuster_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aasa_pkg::*;

  // indexes past the register list, written to check they are ignored
  localparam logic [2:0] CFG_IDX_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int         DRAIN_CYCLES     = 4;
  localparam longint     WINDOW_MAX       = (64'd1 << 21) - 1;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [95:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = CFG_READ_THRESHOLD;
  logic [15:0] cfg_data  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic        cfg_ready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assembly_area_size_adjuster dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Adjuster model: register copies, run counters and held changes
  // --------------------------------------------------------------------------
  logic [7:0]  thr_q    = READ_THRESHOLD_RST;
  logic [7:0]  floor_q  = AREA_FLOOR_RST;
  logic [3:0]  grow_q   = AREA_GROW_STEP_RST;
  logic [15:0] evict_q  = EVICT_ADD_LIMIT_RST;
  logic [15:0] pmin_q   = PROTECT_MIN_RST;

  int unsigned low_run     = 0;
  bit          high_run    = 1'b0;
  logic [3:0]  held_area   = '0;
  longint      held_window = 0;

  result_t pending_changes[$];

  function automatic longint window_step(longint win, longint win_high);
    longint t;
    t = win_high / 70 - win / 70;
    return (win + t <= win_high) ? t : win_high - win;
  endfunction

  function automatic result_t predict_adjust(item_t it);
    longint  area, win, mem, area_ceil, win_low, win_high, flr, ac, wc;
    result_t r;
    area      = longint'(it.area_size);
    win       = longint'(it.window_size);
    mem       = area + longint'(it.cache_size);
    area_ceil = (5 * mem) / 8;
    win_low   = 2 * mem;
    win_high  = 20 * mem;
    flr       = longint'(floor_q);
    ac        = longint'(held_area);
    wc        = held_window;

    if (longint'(it.reads_this_round) > longint'(thr_q)) begin
      low_run  = 0;
      high_run = 1'b1;
    end else begin
      if (low_run < 32'hFFFF) low_run++;
      high_run = 1'b0;
    end

    if (longint'(low_run) > 6 * area) begin
      if (area + longint'(grow_q) - 1 <= area_ceil) ac = longint'(grow_q);
      wc      = (win - 1 <= win_low) ? 1 : 0;
      low_run = 0;
    end else if (high_run) begin
      if (area - 1 >= flr) ac = 0;
      high_run = 1'b0;
      wc       = window_step(win, win_high);
    end else if (low_run % 4 == 0) begin
      ac = 1;
      wc = (win - 1 <= win_low) ? 1 : 0;
    end else begin
      ac = 1;
      wc = 1;
    end

    // resulting area outside [floor, ceil]: keep both
    if (area - 1 + ac < flr || area - 1 + ac > area_ceil) begin
      ac = 1;
      wc = 1;
    end

    if (longint'(it.evict_adds) > longint'(evict_q)) begin
      if (area - 1 >= flr) begin
        ac = 0;
        wc = window_step(win, win_high);
      end else begin
        ac = 1;
        wc = 0;
      end
    end

    if (longint'(it.protected_count) < longint'(pmin_q)) wc = 0;

    held_area         = ac[3:0];
    held_window       = wc;
    r.area_change     = ac[3:0];
    r.window_change   = wc[21:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check results, track register writes, predict accepted rounds
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.area_change   = m_tdata[3:0];
        got.window_change = m_tdata[25:4];
        if (pending_changes.size() == 0) begin
          $error("unexpected result transaction: area_change=%0d window_change=%0d",
                 got.area_change, $signed(got.window_change));
          errors++;
        end else begin
          want = pending_changes.pop_front();
          if (got.area_change !== want.area_change) begin
            $error("area_change: expected %0d, got %0d", want.area_change, got.area_change);
            errors++;
          end
          if (got.window_change !== want.window_change) begin
            $error("window_change: expected %0d, got %0d",
                   $signed(want.window_change), $signed(got.window_change));
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READ_THRESHOLD:  thr_q   = cfg_data[7:0];
          CFG_AREA_FLOOR:      floor_q = cfg_data[7:0];
          CFG_AREA_GROW_STEP:  grow_q  = cfg_data[3:0];
          CFG_EVICT_ADD_LIMIT: evict_q = cfg_data;
          CFG_PROTECT_MIN:     pmin_q  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        pending_changes.push_back(predict_adjust(item_t'{
          reads_this_round: s_tdata[15:0],
          area_size:        s_tdata[25:16],
          cache_size:       s_tdata[41:26],
          window_size:      s_tdata[62:42],
          evict_adds:       s_tdata[78:63],
          protected_count:  s_tdata[94:79]}));
      end
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_round(item_t it);
    s_tdata  <= {1'b0, it.protected_count, it.evict_adds, it.window_size,
                 it.cache_size, it.area_size, it.reads_this_round};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // writes all five registers; upper data bits carry junk that must be dropped
  task automatic write_settings(int thr, int flr, int grow, int lim, int pmin, bit spare);
    logic [15:0] junk;
    logic [2:0]  idx [7];
    logic [15:0] val [7];
    int          n;
    junk   = 16'($urandom);
    idx[0] = CFG_READ_THRESHOLD;  val[0] = {junk[15:8], 8'(thr)};
    idx[1] = CFG_AREA_FLOOR;      val[1] = {junk[7:0], 8'(flr)};
    idx[2] = CFG_AREA_GROW_STEP;  val[2] = {junk[15:4], 4'(grow)};
    idx[3] = CFG_EVICT_ADD_LIMIT; val[3] = 16'(lim);
    idx[4] = CFG_PROTECT_MIN;     val[4] = 16'(pmin);
    idx[5] = CFG_IDX_SPARE_LO;    val[5] = ~junk;
    idx[6] = CFG_IDX_SPARE_HI;    val[6] = junk;
    n = spare ? 7 : 5;
    for (int i = 0; i < n; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // pending queue is checked at the falling edge to stay clear of the monitor
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_changes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Round generation
  // --------------------------------------------------------------------------
  function automatic longint clip_window(longint v);
    return (v < 0) ? 0 : ((v > WINDOW_MAX) ? WINDOW_MAX : v);
  endfunction

  function automatic item_t make_round(longint reads, longint area, longint cache,
                                       longint win, longint eadds, longint pcount);
    item_t it;
    it.reads_this_round = 16'(reads);
    it.area_size        = 10'(area);
    it.cache_size       = 16'(cache);
    it.window_size      = 21'(win);
    it.evict_adds       = 16'(eadds);
    it.protected_count  = 16'(pcount);
    return it;
  endfunction

  function automatic item_t random_round(int area, int cache, bit low_reads);
    item_t  it;
    longint mem, win;
    mem           = area + cache;
    it.area_size  = 10'(area);
    it.cache_size = 16'(cache);
    if (low_reads) begin
      it.reads_this_round = 16'($urandom_range(thr_q, 0));
    end else begin
      case ($urandom_range(3))
        0:       it.reads_this_round = 16'hFFFF;
        1:       it.reads_this_round = 16'(thr_q + 1 + $urandom_range(3));
        default: it.reads_this_round = 16'($urandom_range(16'hFFFF, thr_q + 1));
      endcase
    end
    // windows near the low bound, near the ceiling, at the ends, anywhere
    case ($urandom_range(5))
      0:       win = clip_window(2 * mem + longint'($urandom_range(6)) - 3);
      1:       win = clip_window(20 * mem + longint'($urandom_range(200)) - 100);
      2:       win = ($urandom_range(1) != 0) ? WINDOW_MAX : 0;
      default: win = longint'($urandom_range(WINDOW_MAX));
    endcase
    it.window_size = 21'(win);
    if ($urandom_range(99) < 20 && evict_q != 16'hFFFF)
      it.evict_adds = 16'($urandom_range(16'hFFFF, evict_q + 1));
    else
      it.evict_adds = 16'($urandom_range(evict_q, 0));
    if ($urandom_range(99) < 12 && pmin_q != 0)
      it.protected_count = 16'($urandom_range(pmin_q - 1, 0));
    else
      it.protected_count = 16'($urandom_range(16'hFFFF, pmin_q));
    return it;
  endfunction

  // runs of rounds at one area/cache size, mostly low-read so the run
  // counter climbs into the grow branch; some runs are noisy
  task automatic run_sequences(int n_items);
    int sent;
    int area, cache, len, low_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: area = $urandom_range(4);
        4, 5, 6:    area = $urandom_range(60, 5);
        7:          area = 1023;
        default:    area = $urandom_range(1023);
      endcase
      case ($urandom_range(5))
        0, 1:    cache = $urandom_range(40);
        2, 3:    cache = $urandom_range(2000);
        4:       cache = $urandom_range(16'hFFFF);
        default: cache = 16'hFFFF;
      endcase
      len     = $urandom_range(30, 1);
      if (len > n_items - sent) len = n_items - sent;
      low_pct = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(100, 80);
      repeat (len) begin
        send_round(random_round(area, cache, $urandom_range(99) < low_pct));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset register values
    send_round(make_round(0, 0, 0, 0, 0, 0));
    send_round(make_round(16'hFFFF, 10'h3FF, 16'hFFFF, WINDOW_MAX, 16'hFFFF, 16'hFFFF));
    send_round(make_round(3, 500, 1000, 1000, 0, 16'hFFFF));
    send_round(make_round(3, 500, 1000, 29950, 0, 16'hFFFF));
    // window above the ceiling: step clamps to the ceiling
    send_round(make_round(3, 500, 1000, 40000, 0, 16'hFFFF));
    // threshold edge: equal is low, one above is high
    send_round(make_round(2, 100, 100, 400, 0, 16'hFFFF));
    send_round(make_round(3, 100, 100, 400, 0, 16'hFFFF));
    // evict pressure with area at/above floor, then below floor, then adds at the limit
    send_round(make_round(0, 500, 1000, 5000, 513, 16'hFFFF));
    send_round(make_round(0, 1, 1000, 5000, 16'hFFFF, 16'hFFFF));
    send_round(make_round(0, 500, 1000, 5000, 512, 16'hFFFF));
    // small protected part
    send_round(make_round(3, 500, 1000, 1000, 0, 511));
    // area out of bounds above the ceiling and below the floor
    send_round(make_round(3, 1023, 0, 100, 0, 16'hFFFF));
    send_round(make_round(3, 1, 16'hFFFF, 100, 0, 16'hFFFF));
    // low rounds at the window low bound edge
    send_round(make_round(0, 200, 0, 401, 0, 16'hFFFF));
    send_round(make_round(0, 200, 0, 402, 0, 16'hFFFF));
    send_round(make_round(0, 200, 0, 401, 0, 16'hFFFF));
    send_round(make_round(0, 200, 0, 402, 0, 16'hFFFF));
    wait_idle();
    // rewrite defaults, then hit the unused indexes with junk
    write_settings(2, 2, 2, 512, 512, 1'b1);
    send_round(make_round(3, 500, 1000, 1000, 513, 16'hFFFF));
    send_round(make_round(0, 0, 40, 10, 0, 16'hFFFF));
    send_round(make_round(0, 3, 40, 90, 0, 16'hFFFF));
  endtask

  task automatic test_grow_runs();
    wait_idle();
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    write_settings(2, 0, 15, 512, 0, 1'b0);
    for (int area = 0; area < 4; area++) begin
      repeat (6 * area + 2) send_round(make_round(0, area, 40, 2 * (area + 40), 0, 16'hFFFF));
      send_round(make_round(0, area, 40, 20 * (area + 40), 0, 16'hFFFF));
    end
  endtask

  task automatic test_config_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    // all zero, including a zero grow step
    write_settings(0, 0, 0, 0, 0, 1'b0);
    run_sequences(24);
    wait_idle();
    write_settings(255, 255, 15, 16'hFFFF, 16'hFFFF, 1'b0);
    run_sequences(24);
  endtask

  task automatic test_random_flow(int idle_pct, int stall_pct, int n_items);
    int thr, flr, lim, pmin;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      wait_idle();
      thr  = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(6);
      flr  = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(4);
      lim  = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(1000);
      pmin = ($urandom_range(4) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(300);
      write_settings(thr, flr, $urandom_range(15), lim, pmin, 1'b0);
      run_sequences(n_items / 2);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_grow_runs();
    test_config_extremes();
    test_random_flow(0, 0, 70);
    test_random_flow(71, 0, 70);
    test_random_flow(0, 71, 70);
    test_random_flow(24, 24, 70);
    wait_idle();
    if (errors == 0)
      $display("assembly_area_size_adjuster_tb: done, clean");
    else
      $display("assembly_area_size_adjuster_tb: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("assembly_area_size_adjuster_tb: done, errors");
    $finish;
  end

endmodule
